FILE: sv/frame_length_credential_decoder_top_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the frame length credential decoder
// Shared checks clocked on i_clk and disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef FRAME_LENGTH_CREDENTIAL_DECODER_TOP_ASSERT_SVH
`define FRAME_LENGTH_CREDENTIAL_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FLCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/flcd_pkg.sv
// -----------------------------------------------------------------------------
// flcd_pkg
// Types and constants shared by the frame length credential decoder.
// -----------------------------------------------------------------------------
package flcd_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_NAME_TAG   = 16'd1099;
    localparam logic [LEN_W-1:0] RST_SECRET_TAG = 16'd1199;
    localparam logic [LEN_W-1:0] RST_MARKER_A   = 16'd3;
    localparam logic [LEN_W-1:0] RST_MARKER_B   = 16'd23;
    localparam logic [LEN_W-1:0] RST_COUNT_OFS  = 16'd28;
    localparam logic [LEN_W-1:0] RST_NIBBLE_OFS = 16'd593;

    typedef enum logic [2:0] {
        REG_NAME_TAG   = 3'd0,
        REG_SECRET_TAG = 3'd1,
        REG_MARKER_A   = 3'd2,
        REG_MARKER_B   = 3'd3,
        REG_COUNT_OFS  = 3'd4,
        REG_NIBBLE_OFS = 3'd5
    } t_reg_idx;

    typedef enum logic {
        OP_RESTART = 1'b0,
        OP_FRAME   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NAME   = 2'd1,
        ACT_SECRET = 2'd2
    } t_act;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_RECV  = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0] name_tag;
        logic [LEN_W-1:0] secret_tag;
        logic [LEN_W-1:0] marker_a;
        logic [LEN_W-1:0] marker_b;
        logic [LEN_W-1:0] count_ofs;
        logic [LEN_W-1:0] nibble_ofs;
    } t_cfg;

    // Commands from the control logic to one string receiver
    typedef struct packed {
        logic restart;
        logic open;
        logic take;
    } t_str_ctl;

    // Per-item status from one string receiver
    typedef struct packed {
        logic       go_idle;
        logic       clr_marker;
        logic       check_error;
        logic       byte_valid;
        logic       done;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
    } t_str_stat;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [6:0] secret_byte_count;
        logic [5:0] name_byte_count;
        logic       secret_done;
        logic       name_done;
        logic       check_error;
        logic [7:0] byte_value;
        logic [5:0] byte_index;
        logic       byte_target;
        logic       byte_valid;
        t_act       active_string;
    } t_result;

endpackage

FILE: sv/flcd_cfg.sv
// -----------------------------------------------------------------------------
// flcd_cfg
// APB register file holding the six 16-bit decoder settings.
// -----------------------------------------------------------------------------
module flcd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flcd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [flcd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [flcd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output flcd_pkg::t_cfg                    o_cfg
);

    flcd_pkg::t_cfg   r_cfg;
    flcd_pkg::t_reg_idx reg_sel;
    logic             wr_en;
    logic [flcd_pkg::LEN_W-1:0] wr_val;
    logic [flcd_pkg::LEN_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[flcd_pkg::LEN_W-1:0];
    assign reg_sel = flcd_pkg::t_reg_idx'(paddr[flcd_pkg::CFG_ADDR_W-1:2]);

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.name_tag   <= flcd_pkg::RST_NAME_TAG;
            r_cfg.secret_tag <= flcd_pkg::RST_SECRET_TAG;
            r_cfg.marker_a   <= flcd_pkg::RST_MARKER_A;
            r_cfg.marker_b   <= flcd_pkg::RST_MARKER_B;
            r_cfg.count_ofs  <= flcd_pkg::RST_COUNT_OFS;
            r_cfg.nibble_ofs <= flcd_pkg::RST_NIBBLE_OFS;
        end else if (wr_en) begin
            case (reg_sel)
                flcd_pkg::REG_NAME_TAG:   r_cfg.name_tag   <= wr_val;
                flcd_pkg::REG_SECRET_TAG: r_cfg.secret_tag <= wr_val;
                flcd_pkg::REG_MARKER_A:   r_cfg.marker_a   <= wr_val;
                flcd_pkg::REG_MARKER_B:   r_cfg.marker_b   <= wr_val;
                flcd_pkg::REG_COUNT_OFS:  r_cfg.count_ofs  <= wr_val;
                flcd_pkg::REG_NIBBLE_OFS: r_cfg.nibble_ofs <= wr_val;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_sel)
            flcd_pkg::REG_NAME_TAG:   rd_val = r_cfg.name_tag;
            flcd_pkg::REG_SECRET_TAG: rd_val = r_cfg.secret_tag;
            flcd_pkg::REG_MARKER_A:   rd_val = r_cfg.marker_a;
            flcd_pkg::REG_MARKER_B:   rd_val = r_cfg.marker_b;
            flcd_pkg::REG_COUNT_OFS:  rd_val = r_cfg.count_ofs;
            flcd_pkg::REG_NIBBLE_OFS: rd_val = r_cfg.nibble_ofs;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = flcd_pkg::CFG_DATA_W'(rd_val);
    assign o_cfg  = r_cfg;

endmodule

FILE: sv/flcd_string.sv
// -----------------------------------------------------------------------------
// flcd_string
// Receiver state for one length-encoded string: declared byte count, nibble
// counter, previous nibble and phase, with the per-item nibble check.
// -----------------------------------------------------------------------------
module flcd_string #(
    parameter int MAX_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  flcd_pkg::t_str_ctl          i_ctl,
    input  logic [flcd_pkg::LEN_W-1:0]  i_len,
    input  logic [flcd_pkg::LEN_W-1:0]  i_count_ofs,
    input  logic [flcd_pkg::LEN_W-1:0]  i_nibble_ofs,
    output logic                        o_done_q,
    output flcd_pkg::t_str_stat         o_stat,
    output logic [$clog2(MAX_BYTES+1)-1:0] o_byte_count
);

    localparam int BC_W = $clog2(MAX_BYTES + 1);
    localparam int NC_W = BC_W + 1;

    flcd_pkg::t_phase  r_phase, n_phase;
    logic [BC_W-1:0]   r_bytes, n_bytes;
    logic [NC_W-1:0]   r_count, n_count;
    logic [3:0]        r_last,  n_last;

    logic [NC_W-1:0]            total;
    logic [7:0]                 count_ext;
    logic [flcd_pkg::LEN_W-1:0] diff;
    logic [flcd_pkg::LEN_W-1:0] adj;
    logic                       count_bad;
    logic [3:0]                 nib;
    logic [3:0]                 chk;

    assign total     = {r_bytes, 1'b0};
    assign count_ext = 8'(r_count);
    assign diff      = i_len - i_count_ofs;
    assign count_bad = (i_len < i_count_ofs) ||
                       (diff > flcd_pkg::LEN_W'(MAX_BYTES));
    assign adj       = i_len - i_nibble_ofs;
    assign nib       = adj[3:0];
    assign chk       = adj[7:4];

    // Next state and item status
    always_comb begin
        n_phase = r_phase;
        n_bytes = r_bytes;
        n_count = r_count;
        n_last  = r_last;
        o_stat  = '0;
        if (i_ctl.restart) begin
            n_phase = flcd_pkg::PH_AWAIT;
            n_bytes = '0;
            n_count = '0;
            n_last  = '0;
        end else if (i_ctl.open) begin
            n_phase = flcd_pkg::PH_AWAIT;
            n_bytes = '0;
        end else if (i_ctl.take) begin
            if (r_phase == flcd_pkg::PH_AWAIT) begin
                // Declared byte count
                if (count_bad) begin
                    o_stat.go_idle = 1'b1;
                end else begin
                    n_bytes           = BC_W'(diff);
                    n_count           = '0;
                    n_phase           = flcd_pkg::PH_RECV;
                    o_stat.clr_marker = 1'b1;
                end
            end else if (r_count < total) begin
                // One nibble with its check
                o_stat.clr_marker = 1'b1;
                if ((r_count != '0) && (chk != (r_last ^ count_ext[3:0]))) begin
                    o_stat.go_idle     = 1'b1;
                    o_stat.check_error = 1'b1;
                end
                if (r_count[0]) begin
                    o_stat.byte_valid = 1'b1;
                    o_stat.byte_index = 6'(count_ext >> 1);
                    o_stat.byte_value = {r_last, nib};
                end
                n_last  = nib;
                n_count = r_count + 1'b1;
            end else if (r_count == total) begin
                // Closing length after the last nibble
                o_stat.go_idle = 1'b1;
                n_phase        = flcd_pkg::PH_DONE;
            end else begin
                o_stat.go_idle = 1'b1;
            end
        end
        o_stat.done = (n_phase == flcd_pkg::PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= flcd_pkg::PH_AWAIT;
            r_bytes <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            r_phase <= n_phase;
            r_bytes <= n_bytes;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    assign o_done_q     = (r_phase == flcd_pkg::PH_DONE);
    assign o_byte_count = n_bytes;

endmodule

FILE: sv/frame_length_credential_decoder_top.sv
// -----------------------------------------------------------------------------
// frame_length_credential_decoder_top
// Decodes a network name and a password sent as a stream of frame lengths.
// -----------------------------------------------------------------------------
// The block takes one transfer per clock on the slave side while the master
// side takes its results, and returns one result per transfer on the master
// side, in order. A transfer is captured in an input register, decoded
// against the string state by short compare and subtract logic, and lands
// in a result register, from which it is offered on the master side. Both
// registers advance together when the result register is free or being
// taken, which keeps one item per cycle while the master side takes results
// and holds both registers while it stalls. Settings must only be written
// over the APB port while no item is in flight; the block itself does not
// enforce this. The decoder has no memory to initialise after reset.
`include "frame_length_credential_decoder_top_assert.svh"

module frame_length_credential_decoder_top #(
    parameter int MAX_NAME_BYTES   = 32,
    parameter int MAX_SECRET_BYTES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [flcd_pkg::IN_DATA_W-1:0]    s_tdata,  // [15:0] frame_length
    input  logic                              s_tuser,  // [0] opcode
    // Master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] active_string, [2] byte_valid, [3] byte_target, [9:4] byte_index,
    // [17:10] byte_value, [18] check_error, [19] name_done, [20] secret_done,
    // [26:21] name_byte_count, [33:27] secret_byte_count, [39:34] zero
    output logic [flcd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flcd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [flcd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [flcd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int NAME_BC_W   = $clog2(MAX_NAME_BYTES + 1);
    localparam int SECRET_BC_W = $clog2(MAX_SECRET_BYTES + 1);

    flcd_pkg::t_cfg cfg;

    // Input register
    logic                       r_in_valid;
    flcd_pkg::t_op              r_in_op;
    logic [flcd_pkg::LEN_W-1:0] r_in_len;

    // Result register
    logic                       r_out_valid;
    flcd_pkg::t_result          r_out;
    flcd_pkg::t_result          n_out;

    // Decoder control state
    flcd_pkg::t_act             r_active, n_active, base_active;
    logic                       r_marker, n_marker, base_marker;

    logic                       advance_out;
    logic                       proc;
    logic                       is_marker;

    flcd_pkg::t_str_ctl         name_ctl, secret_ctl;
    flcd_pkg::t_str_stat        name_stat, secret_stat;
    logic                       name_done_q, secret_done_q;
    logic [NAME_BC_W-1:0]       name_bc;
    logic [SECRET_BC_W-1:0]     secret_bc;

    // Result fields seen by the assertions
    logic                       out_idle;
    logic                       out_byte;
    logic                       out_owner;
    flcd_pkg::t_act             out_owner_act;

    flcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: both registers move together
    assign advance_out = !r_out_valid || m_tready;
    assign s_tready    = !r_in_valid || advance_out;
    assign proc        = r_in_valid && advance_out;

    // Capture a transfer, drop it once it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_op  <= flcd_pkg::t_op'(s_tuser);
            r_in_len <= s_tdata;
        end
    end

    assign is_marker = (r_in_len == cfg.marker_a) || (r_in_len == cfg.marker_b);

    // Route the item: restart, open a string, marker or data
    always_comb begin
        base_active = r_active;
        base_marker = r_marker;
        name_ctl    = '0;
        secret_ctl  = '0;
        if (proc) begin
            if (r_in_op == flcd_pkg::OP_RESTART) begin
                name_ctl.restart   = 1'b1;
                secret_ctl.restart = 1'b1;
                base_active        = flcd_pkg::ACT_NONE;
                base_marker        = 1'b0;
            end else if (r_active == flcd_pkg::ACT_NONE) begin
                base_marker = 1'b0;
                if ((r_in_len == cfg.name_tag) && !name_done_q) begin
                    base_active   = flcd_pkg::ACT_NAME;
                    name_ctl.open = 1'b1;
                end else if ((r_in_len == cfg.secret_tag) && !secret_done_q) begin
                    base_active     = flcd_pkg::ACT_SECRET;
                    secret_ctl.open = 1'b1;
                end
            end else if (is_marker) begin
                if (r_marker) begin
                    base_active = flcd_pkg::ACT_NONE;
                end else begin
                    base_marker = 1'b1;
                end
            end else if (!r_marker) begin
                base_active = flcd_pkg::ACT_NONE;
            end else if (r_active == flcd_pkg::ACT_NAME) begin
                name_ctl.take = 1'b1;
            end else begin
                secret_ctl.take = 1'b1;
            end
        end
    end

    // Apply what the string receiver reports for a data length
    always_comb begin
        n_active = base_active;
        n_marker = base_marker;
        if (name_stat.go_idle || secret_stat.go_idle) begin
            n_active = flcd_pkg::ACT_NONE;
        end
        if (name_stat.clr_marker || secret_stat.clr_marker) begin
            n_marker = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= flcd_pkg::ACT_NONE;
            r_marker <= 1'b0;
        end else begin
            r_active <= n_active;
            r_marker <= n_marker;
        end
    end

    flcd_string #(
        .MAX_BYTES (MAX_NAME_BYTES)
    ) u_name (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (name_ctl),
        .i_len        (r_in_len),
        .i_count_ofs  (cfg.count_ofs),
        .i_nibble_ofs (cfg.nibble_ofs),
        .o_done_q     (name_done_q),
        .o_stat       (name_stat),
        .o_byte_count (name_bc)
    );

    flcd_string #(
        .MAX_BYTES (MAX_SECRET_BYTES)
    ) u_secret (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (secret_ctl),
        .i_len        (r_in_len),
        .i_count_ofs  (cfg.count_ofs),
        .i_nibble_ofs (cfg.nibble_ofs),
        .o_done_q     (secret_done_q),
        .o_stat       (secret_stat),
        .o_byte_count (secret_bc)
    );

    // Assemble the result; only the string that took the item reports a byte
    always_comb begin
        n_out.active_string     = n_active;
        n_out.byte_valid        = name_stat.byte_valid | secret_stat.byte_valid;
        n_out.byte_target       = secret_stat.byte_valid;
        n_out.byte_index        = name_stat.byte_index | secret_stat.byte_index;
        n_out.byte_value        = name_stat.byte_value | secret_stat.byte_value;
        n_out.check_error       = name_stat.check_error | secret_stat.check_error;
        n_out.name_done         = name_stat.done;
        n_out.secret_done       = secret_stat.done;
        n_out.name_byte_count   = 6'(name_bc);
        n_out.secret_byte_count = 7'(secret_bc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = flcd_pkg::OUT_DATA_W'(r_out);

    // Decode the result register for the checks below
    assign out_idle      = (r_out.active_string == flcd_pkg::ACT_NONE);
    assign out_byte      = r_out_valid && r_out.byte_valid && !r_out.check_error;
    assign out_owner_act = r_out.byte_target ? flcd_pkg::ACT_SECRET : flcd_pkg::ACT_NAME;
    assign out_owner     = (r_out.active_string == out_owner_act);

    // A failed check always leaves the decoder idle
    `FLCD_ASSERT_SAME(a_err_idle, r_out_valid && r_out.check_error, out_idle, "error not idle")
    // A finished name is never reopened
    `FLCD_ASSERT_SAME(a_name_done_closed, r_active == flcd_pkg::ACT_NAME, !name_done_q, "name reopened")
    // A byte without check error keeps its string active
    `FLCD_ASSERT_SAME(a_byte_owner, out_byte, out_owner, "byte from inactive string")
    // A held item stays in the input register while the result is stalled
    `FLCD_ASSERT_NEXT(a_in_hold, r_in_valid && !advance_out, r_in_valid, "input item lost")

endmodule

FILE: sim/frame_length_credential_decoder_top_test.sv
// -----------------------------------------------------------------------------
// frame_length_credential_decoder_top_test
// Drives frame lengths and restarts into the decoder: a directed table, then
// random name and password sequences under several register settings, with
// random idling on both stream sides. Each result is checked field by field
// against the directed table's expected values or an in-bench model of the string decoders.
// -----------------------------------------------------------------------------
module frame_length_credential_decoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import flcd_pkg::*;

    localparam int MAX_NAME_BYTES   = 32;
    localparam int MAX_SECRET_BYTES = 64;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct {
        t_op         op;
        logic [15:0] len;
        bit          typed;
        t_result     want;
    } t_stim_row;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Model state: register shadow and both string decoders
    t_cfg        cfg;
    t_act        cur_string;
    logic        sep_pending;
    t_phase      name_ph, pass_ph;
    logic [7:0]  name_nib_idx, name_nib_total, pass_nib_idx, pass_nib_total;
    logic [3:0]  name_prev_nib, pass_prev_nib;

    t_result     decoder_reports_due[$];
    t_stim_row   directed_rows[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    int          snd_idle_pct   = 14;
    int          rcv_idle_pct   = 68;

    frame_length_credential_decoder_top #(
        .MAX_NAME_BYTES   (MAX_NAME_BYTES),
        .MAX_SECRET_BYTES (MAX_SECRET_BYTES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Put both decoders back to their reset state, registers kept
    task automatic clear_decoder();
        cur_string     = ACT_NONE;
        sep_pending    = 1'b0;
        name_ph        = PH_AWAIT;
        name_nib_idx   = '0;
        name_nib_total = '0;
        name_prev_nib  = '0;
        pass_ph        = PH_AWAIT;
        pass_nib_idx   = '0;
        pass_nib_total = '0;
        pass_prev_nib  = '0;
    endtask

    // One data length for the active string, separator already seen
    task automatic take_nibble_length(input logic [15:0] len, input int max_bytes,
                                      input logic target, inout t_phase ph,
                                      inout logic [7:0] idx, inout logic [7:0] total,
                                      inout logic [3:0] prev, inout t_result res);
        logic [15:0] adj;
        int unsigned declared;
        declared = len - cfg.count_ofs;
        adj      = len - cfg.nibble_ofs;
        if (ph == PH_AWAIT) begin
            if (len < cfg.count_ofs || declared > max_bytes) begin
                cur_string = ACT_NONE;
            end else begin
                total       = 8'(declared * 2);
                idx         = '0;
                ph          = PH_RECV;
                sep_pending = 1'b0;
            end
        end else if (idx < total) begin
            sep_pending = 1'b0;
            if (idx != 0 && adj[7:4] != (prev ^ idx[3:0])) begin
                cur_string        = ACT_NONE;
                res.check_error   = 1'b1;
            end
            // odd nibble closes a byte, high nibble first
            if (idx[0]) begin
                res.byte_valid  = 1'b1;
                res.byte_target = target;
                res.byte_index  = idx[6:1];
                res.byte_value  = {prev, adj[3:0]};
            end
            prev = adj[3:0];
            idx  = idx + 8'd1;
        end else if (idx == total) begin
            cur_string = ACT_NONE;
            ph         = PH_DONE;
        end else begin
            cur_string = ACT_NONE;
        end
    endtask

    // Advance the model by one input and form the report it causes
    task automatic decode_length_item(input t_op op, input logic [15:0] len,
                                      output t_result res);
        res = '0;
        if (op == OP_RESTART) begin
            clear_decoder();
        end else if (cur_string == ACT_NONE) begin
            sep_pending = 1'b0;
            if (len == cfg.name_tag && name_ph != PH_DONE) begin
                cur_string     = ACT_NAME;
                name_nib_total = '0;
                name_ph        = PH_AWAIT;
            end else if (len == cfg.secret_tag && pass_ph != PH_DONE) begin
                cur_string     = ACT_SECRET;
                pass_nib_total = '0;
                pass_ph        = PH_AWAIT;
            end
        end else if (len == cfg.marker_a || len == cfg.marker_b) begin
            if (sep_pending) begin
                cur_string = ACT_NONE;
            end else begin
                sep_pending = 1'b1;
            end
        end else if (!sep_pending) begin
            cur_string = ACT_NONE;
        end else if (cur_string == ACT_NAME) begin
            take_nibble_length(len, MAX_NAME_BYTES, 1'b0, name_ph, name_nib_idx,
                               name_nib_total, name_prev_nib, res);
        end else begin
            take_nibble_length(len, MAX_SECRET_BYTES, 1'b1, pass_ph, pass_nib_idx,
                               pass_nib_total, pass_prev_nib, res);
        end
        res.active_string     = cur_string;
        res.name_done         = (name_ph == PH_DONE);
        res.secret_done       = (pass_ph == PH_DONE);
        res.name_byte_count   = name_nib_total[6:1];
        res.secret_byte_count = pass_nib_total[7:1];
    endtask

    function automatic t_result exp_res(t_act act, logic bv, logic [7:0] bval, logic cerr,
                                        logic sdone, logic [5:0] ncnt);
        t_result r;
        r                 = '0;
        r.active_string   = act;
        r.byte_valid      = bv;
        r.byte_value      = bval;
        r.check_error     = cerr;
        r.secret_done     = sdone;
        r.name_byte_count = ncnt;
        return r;
    endfunction

    task automatic add_row(t_op op, logic [15:0] len, bit typed, t_result want);
        t_stim_row row;
        row.op    = op;
        row.len   = len;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Present one item, hold it until taken, then queue its report
    task automatic send_length(t_op op, logic [15:0] len, bit typed, t_result want);
        t_result res;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= len;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        decode_length_item(op, len, res);
        decoder_reports_due.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic send_separator();
        send_length(OP_FRAME, $urandom_range(1) ? cfg.marker_a : cfg.marker_b, 1'b0, '0);
    endtask

    // One name or password sequence, with a few broken pieces now and then
    task automatic send_random_string();
        bit          to_secret;
        int          nbytes;
        int          max_bytes;
        int          k;
        logic [3:0]  prev_nib, nib, chk;
        logic [15:0] tag;
        to_secret = 1'($urandom_range(1));
        max_bytes = to_secret ? MAX_SECRET_BYTES : MAX_NAME_BYTES;
        tag       = to_secret ? cfg.secret_tag : cfg.name_tag;
        case ($urandom_range(29))
            0:       nbytes = max_bytes;
            1:       nbytes = max_bytes + 1;
            default: nbytes = $urandom_range(4);
        endcase
        prev_nib = '0;
        // restart often enough that finished strings open again
        if ($urandom_range(1) == 0) begin
            send_length(OP_RESTART, 16'($urandom), 1'b0, '0);
        end
        send_length(OP_FRAME, tag, 1'b0, '0);
        send_separator();
        send_length(OP_FRAME, cfg.count_ofs + 16'(nbytes), 1'b0, '0);
        for (k = 0; k <= 2 * nbytes; k++) begin
            // drop or double the separator now and then
            case ($urandom_range(49))
                0: ;
                1: begin
                    send_separator();
                    send_separator();
                end
                default: send_separator();
            endcase
            nib = 4'($urandom);
            chk = (k == 0) ? 4'($urandom) : prev_nib ^ 4'(k);
            if ($urandom_range(49) == 0) begin
                chk = ~chk;
            end
            send_length(OP_FRAME, cfg.nibble_ofs + {8'd0, chk, nib}, 1'b0, '0);
            prev_nib = nib;
        end
    endtask

    task automatic run_random(int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal) begin
            if ($urandom_range(9) == 0) begin
                send_length(($urandom_range(3) == 0) ? OP_RESTART : OP_FRAME,
                            16'($urandom_range(65535)), 1'b0, '0);
            end else begin
                send_random_string();
            end
        end
    endtask

    // Stop sending and let every pending report come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (decoder_reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // hold the bus idle between writes
        @(posedge i_clk);
        case (idx)
            REG_NAME_TAG:   cfg.name_tag   = val;
            REG_SECRET_TAG: cfg.secret_tag = val;
            REG_MARKER_A:   cfg.marker_a   = val;
            REG_MARKER_B:   cfg.marker_b   = val;
            REG_COUNT_OFS:  cfg.count_ofs  = val;
            REG_NIBBLE_OFS: cfg.nibble_ofs = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] ntag, logic [15:0] stag, logic [15:0] ma,
                              logic [15:0] mb, logic [15:0] cofs, logic [15:0] nofs);
        write_reg(REG_NAME_TAG, ntag);
        write_reg(REG_SECRET_TAG, stag);
        write_reg(REG_MARKER_A, ma);
        write_reg(REG_MARKER_B, mb);
        write_reg(REG_COUNT_OFS, cofs);
        write_reg(REG_NIBBLE_OFS, nofs);
    endtask

    // Receiver: stall at random
    initial begin
        forever begin
            @(posedge i_clk);
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transfer with the oldest pending report
    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[33:0];
            if (decoder_reports_due.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = decoder_reports_due.pop_front();
                check_field("active_string", want.active_string, got.active_string);
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("byte_target", want.byte_target, got.byte_target);
                check_field("byte_index", want.byte_index, got.byte_index);
                check_field("byte_value", want.byte_value, got.byte_value);
                check_field("check_error", want.check_error, got.check_error);
                check_field("name_done", want.name_done, got.name_done);
                check_field("secret_done", want.secret_done, got.secret_done);
                check_field("name_byte_count", want.name_byte_count, got.name_byte_count);
                check_field("secret_byte_count", want.secret_byte_count,
                            got.secret_byte_count);
                check_field("pad", 0, m_tdata[OUT_DATA_W-1:34]);
            end
        end
    end

    // Main sequence
    initial begin
        cfg = '{RST_NAME_TAG, RST_SECRET_TAG, RST_MARKER_A, RST_MARKER_B,
                RST_COUNT_OFS, RST_NIBBLE_OFS};
        clear_decoder();

        // Directed table at reset settings
        add_row(OP_FRAME, 16'hFFFF, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 0, 6'd0));
        add_row(OP_FRAME, RST_NAME_TAG, 1'b1, exp_res(ACT_NAME, 0, 8'h00, 0, 0, 6'd0));
        add_row(OP_FRAME, RST_MARKER_A, 1'b1, exp_res(ACT_NAME, 0, 8'h00, 0, 0, 6'd0));
        // two separators in a row
        add_row(OP_FRAME, RST_MARKER_A, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 0, 6'd0));
        add_row(OP_FRAME, RST_NAME_TAG, 1'b0, '0);
        add_row(OP_FRAME, RST_MARKER_B, 1'b0, '0);
        add_row(OP_FRAME, RST_COUNT_OFS + 16'd2, 1'b1,
                exp_res(ACT_NAME, 0, 8'h00, 0, 0, 6'd2));
        add_row(OP_FRAME, RST_MARKER_A, 1'b0, '0);
        add_row(OP_FRAME, RST_NIBBLE_OFS + 16'h04, 1'b0, '0);
        add_row(OP_FRAME, RST_MARKER_B, 1'b0, '0);
        // bad check nibble that still closes a byte
        add_row(OP_FRAME, RST_NIBBLE_OFS + 16'h01, 1'b1,
                exp_res(ACT_NONE, 1, 8'h41, 1, 0, 6'd2));
        // data length with no separator before it
        add_row(OP_FRAME, RST_NAME_TAG, 1'b0, '0);
        add_row(OP_FRAME, 16'h0000, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 0, 6'd0));
        // declared count over the buffer size
        add_row(OP_FRAME, RST_SECRET_TAG, 1'b0, '0);
        add_row(OP_FRAME, RST_MARKER_A, 1'b0, '0);
        add_row(OP_FRAME, RST_COUNT_OFS + 16'd65, 1'b1,
                exp_res(ACT_NONE, 0, 8'h00, 0, 0, 6'd0));
        // empty password runs to completion
        add_row(OP_FRAME, RST_SECRET_TAG, 1'b0, '0);
        add_row(OP_FRAME, RST_MARKER_A, 1'b0, '0);
        add_row(OP_FRAME, RST_COUNT_OFS, 1'b0, '0);
        add_row(OP_FRAME, RST_MARKER_B, 1'b0, '0);
        add_row(OP_FRAME, 16'd999, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 1, 6'd0));
        // finished string does not open again
        add_row(OP_FRAME, RST_SECRET_TAG, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 1, 6'd0));
        add_row(OP_RESTART, 16'h0000, 1'b1, exp_res(ACT_NONE, 0, 8'h00, 0, 0, 6'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_length(directed_rows[i].op, directed_rows[i].len,
                        directed_rows[i].typed, directed_rows[i].want);
        end
        run_random(200);

        // Low extremes
        wait_drain();
        set_config(16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 16'd0, 16'd0);
        run_random(150);

        // High extremes, idling swapped
        wait_drain();
        snd_idle_pct = 68;
        rcv_idle_pct = 14;
        set_config(16'hFFFF, 16'hFFFE, 16'd0, 16'd300, 16'hFFFF, 16'hFFFF);
        run_random(100);

        // Random settings
        wait_drain();
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(60000)), 16'($urandom));
        run_random(200);

        // Back to reset settings, no idling
        wait_drain();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_config(RST_NAME_TAG, RST_SECRET_TAG, RST_MARKER_A, RST_MARKER_B,
                   RST_COUNT_OFS, RST_NIBBLE_OFS);
        run_random(150);

        wait_drain();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/flcd_pkg.sv
sv/flcd_cfg.sv
sv/flcd_string.sv
sv/frame_length_credential_decoder_top.sv
sim/frame_length_credential_decoder_top_test.sv
